### src/ect_pkg.sv
// Event counter table: shared constants, operation and status codes.
// No dependencies; used by all modules in src.
package ect_pkg;
   localparam int DEF_SLOTS = 64;
   localparam logic [30:0] DEF_FIRST_HANDLE = 31'd12000;

   localparam logic [2:0] OP_CREATE = 3'd0;
   localparam logic [2:0] OP_READ   = 3'd1;
   localparam logic [2:0] OP_WRITE  = 3'd2;
   localparam logic [2:0] OP_CLOSE  = 3'd3;
   localparam logic [2:0] OP_CLOSE_OWNER = 3'd4;
   localparam logic [2:0] OP_POLL   = 3'd5;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_BADH  = 3'd1;
   localparam logic [2:0] ST_BLOCK = 3'd2;
   localparam logic [2:0] ST_OVF   = 3'd3;
   localparam logic [2:0] ST_FULL  = 3'd4;

   // result of the slot tag search
   typedef struct packed {
      logic hit;
      logic free_found;
   } match_type;
endpackage

### src/event_counter_table.sv
// Event counter table top level: request decode, counter memory
// read-modify-write, response register. Depends on ect_pkg, ect_match.
// Create, close, close by owner and the unused modes are settled in the
// accepting cycle; their response is valid on the next cycle. Read, write
// and poll do a tag search plus counter memory read in the accepting
// cycle, then the update and write-back, which also registers the
// response; the input stays stalled meanwhile. The 64-bit counters and
// semaphore bits sit in a synchronous memory with a registered read; used
// marks, handles and owners are kept in flip-flops for the search. A new
// request is taken once no update is in progress and the previous response
// register is free or being drained. No clearing pass after reset.
module event_counter_table_core #(
   parameter int SLOTS = ect_pkg::DEF_SLOTS,
   parameter logic [30:0] FIRST_HANDLE = ect_pkg::DEF_FIRST_HANDLE
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode[2:0], handle[33:3], init_value[65:34], semaphore_mode[66],
   // owner[98:67], add_value[162:99], zero fill to 168
   input  logic [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[2:0], new_handle[33:3], read_value[97:34], readable[98],
   // writable[99], zero fill to 104
   output logic [103:0] rsp_tdata
);
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [2:0]  r_mode;
   logic [30:0] r_handle;
   logic [31:0] r_init;
   logic        r_sem;
   logic [31:0] r_owner;
   logic [63:0] r_add;
   assign r_mode   = req_tdata[2:0];
   assign r_handle = req_tdata[33:3];
   assign r_init   = req_tdata[65:34];
   assign r_sem    = req_tdata[66];
   assign r_owner  = req_tdata[98:67];
   assign r_add    = req_tdata[162:99];

   logic [SLOTS-1:0]       used_ff;
   logic [SLOTS-1:0][30:0] handle_ff;
   logic [SLOTS-1:0][31:0] owner_ff;
   logic [30:0]            next_handle_ff;
   logic [64:0]            mem [SLOTS];   // {semaphore, count}
   logic [64:0]            mem_q_ff;

   logic                   busy_ff;
   logic [2:0]             mode_ff;
   logic [63:0]            add_ff;
   logic                   hit_ff;
   logic [IW-1:0]          idx_ff;

   logic                   rsp_valid_ff;
   logic [103:0]           rsp_data_ff;

   ect_pkg::match_type     flags;
   logic [IW-1:0]          hit_idx, free_idx;
   logic [SLOTS-1:0]       owner_hits;

   ect_match #(.SLOTS(SLOTS)) u_match (
      .used(used_ff), .handles(handle_ff), .owners(owner_ff),
      .handle(r_handle), .owner(r_owner), .flags(flags),
      .hit_idx(hit_idx), .free_idx(free_idx), .owner_hits(owner_hits)
   );

   logic accept;
   assign req_tready = !reset && !busy_ff && (!rsp_valid_ff || rsp_tready);
   assign accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   // busy step: update from the registered memory data
   logic [63:0] cnt, sum, wb_cnt;
   logic        sem, carry, wb_en;
   logic [2:0]  st;
   logic [63:0] rv;
   logic        rd, wr;
   always_comb begin
      cnt = mem_q_ff[63:0];
      sem = mem_q_ff[64];
      {carry, sum} = {1'b0, cnt} + {1'b0, add_ff};
      st = ect_pkg::ST_OK;
      rv = '0; rd = 1'b0; wr = 1'b0;
      wb_en = 1'b0; wb_cnt = cnt;
      case (mode_ff)
         ect_pkg::OP_READ: begin
            if (!hit_ff) st = ect_pkg::ST_BADH;
            else if (cnt == '0) st = ect_pkg::ST_BLOCK;
            else if (sem) begin
               rv = 64'd1; wb_cnt = cnt - 64'd1; wb_en = 1'b1;
            end else begin
               rv = cnt; wb_cnt = '0; wb_en = 1'b1;
            end
         end
         ect_pkg::OP_WRITE: begin
            if (!hit_ff) st = ect_pkg::ST_BADH;
            else if (carry) st = ect_pkg::ST_OVF;
            else begin
               wb_cnt = sum; wb_en = 1'b1;
            end
         end
         ect_pkg::OP_POLL: begin
            if (!hit_ff) st = ect_pkg::ST_BADH;
            else begin
               rd = cnt != '0; wr = cnt != '1;
            end
         end
         default: ;
      endcase
   end

   // accepting-cycle decisions for create/close/close-owner
   logic        cr_ok;
   assign cr_ok = flags.free_found;

   always_ff @(posedge clock) begin
      if (accept) begin
         mem_q_ff <= mem[hit_idx];
         mode_ff <= r_mode;
         add_ff <= r_add;
         hit_ff <= flags.hit;
         idx_ff <= hit_idx;
      end
      if (accept && r_mode == ect_pkg::OP_CREATE && cr_ok)
         mem[free_idx] <= {r_sem, 32'd0, r_init};
      else if (busy_ff && wb_en)
         mem[idx_ff] <= {sem, wb_cnt};
      if (accept && r_mode == ect_pkg::OP_CREATE && cr_ok) begin
         handle_ff[free_idx] <= next_handle_ff;
         owner_ff[free_idx] <= r_owner;
      end
      if (busy_ff) rsp_data_ff <= {4'd0, wr, rd, rv, 31'd0, st};
      else if (accept && r_mode == ect_pkg::OP_CREATE)
         rsp_data_ff <= cr_ok ? {4'd0, 2'b00, 64'd0, next_handle_ff, ect_pkg::ST_OK}
                              : {4'd0, 2'b00, 64'd0, 31'd0, ect_pkg::ST_FULL};
      else if (accept && r_mode == ect_pkg::OP_CLOSE)
         rsp_data_ff <= {4'd0, 2'b00, 64'd0, 31'd0,
                         flags.hit ? ect_pkg::ST_OK : ect_pkg::ST_BADH};
      else if (accept)
         rsp_data_ff <= '0;

      if (reset) begin
         used_ff <= '0;
         next_handle_ff <= FIRST_HANDLE;
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            unique case (r_mode)
               ect_pkg::OP_CREATE: if (cr_ok) begin
                  used_ff[free_idx] <= 1'b1;
                  next_handle_ff <= next_handle_ff + 31'd1;
               end
               ect_pkg::OP_CLOSE: if (flags.hit) used_ff[hit_idx] <= 1'b0;
               ect_pkg::OP_CLOSE_OWNER: used_ff <= used_ff & ~owner_hits;
               default: ;
            endcase
         end
         // read/write/poll need the memory data: they go busy for the update
         busy_ff <= accept && (r_mode == ect_pkg::OP_READ ||
                    r_mode == ect_pkg::OP_WRITE || r_mode == ect_pkg::OP_POLL);
         if (busy_ff) rsp_valid_ff <= 1'b1;
         else if (accept)
            rsp_valid_ff <= !(r_mode == ect_pkg::OP_READ ||
                    r_mode == ect_pkg::OP_WRITE || r_mode == ect_pkg::OP_POLL);
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end
endmodule

### src/ect_match.sv
// Event counter table: slot tag search (handle match, first free slot,
// owner match). Tags live in flip-flops. Depends on ect_pkg.
module ect_match #(
   parameter int SLOTS = ect_pkg::DEF_SLOTS,
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic [SLOTS-1:0]       used,
   input  logic [SLOTS-1:0][30:0] handles,
   input  logic [SLOTS-1:0][31:0] owners,
   input  logic [30:0]            handle,
   input  logic [31:0]            owner,
   output ect_pkg::match_type     flags,
   output logic [IW-1:0]          hit_idx,
   output logic [IW-1:0]          free_idx,
   output logic [SLOTS-1:0]       owner_hits
);
   always_comb begin
      flags = '0;
      hit_idx = '0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (used[i] && handles[i] == handle) begin
            flags.hit = 1'b1;
            hit_idx = IW'(i);
         end
         if (!used[i]) begin
            flags.free_found = 1'b1;
            free_idx = IW'(i);
         end
         owner_hits[i] = used[i] && owners[i] == owner;
      end
   end
endmodule

### bench/event_counter_table_core_test.sv
// Self-checking bench for event_counter_table_core: random and directed requests,
// a built-in predictor of the slot table, and a response checker. Depends on ect_pkg.
`timescale 1ns / 1ps

module event_counter_table_core_test;
   localparam int NSLOT = ect_pkg::DEF_SLOTS;
   localparam int TIMEOUT = 20000;

   typedef struct packed {
      logic [63:0] add_value;
      logic [31:0] owner;
      logic        semaphore_mode;
      logic [31:0] init_value;
      logic [30:0] handle;
      logic [2:0]  mode;
   } request_type;

   typedef struct packed {
      logic        writable;
      logic        readable;
      logic [63:0] read_value;
      logic [30:0] new_handle;
      logic [2:0]  status;
   } response_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [167:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [103:0] rsp_tdata;

   event_counter_table_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #6 clock = ~clock;

   // predictor state
   logic        tbl_used [NSLOT];
   logic [30:0] tbl_handle [NSLOT];
   logic [31:0] tbl_owner [NSLOT];
   logic [63:0] tbl_count [NSLOT];
   logic        tbl_sem [NSLOT];
   logic [30:0] tbl_next;

   request_type  pending_reqs[$];
   response_type expected_rsps[$];
   int        errors = 0;
   int        sent = 0;
   bit        stim_done = 0;
   bit        hold_go = 0;
   bit        hold_seen = 0;
   int        hold_left = 0;
   int        idle_cycles = 0;

   function automatic int find_slot(logic [30:0] h);
      for (int i = 0; i < NSLOT; i++)
         if (tbl_used[i] && tbl_handle[i] == h) return i;
      return -1;
   endfunction

   function automatic response_type predict_counter_op(request_type r);
      response_type o;
      int i;
      logic [63:0] sum;
      o = '0;
      o.status = ect_pkg::ST_OK;
      case (r.mode)
         ect_pkg::OP_CREATE: begin
            i = -1;
            for (int k = 0; k < NSLOT; k++)
               if (i < 0 && !tbl_used[k]) i = k;
            if (i < 0) o.status = ect_pkg::ST_FULL;
            else begin
               tbl_used[i] = 1; tbl_handle[i] = tbl_next; tbl_owner[i] = r.owner;
               tbl_count[i] = {32'd0, r.init_value}; tbl_sem[i] = r.semaphore_mode;
               o.new_handle = tbl_next;
               tbl_next = tbl_next + 31'd1;
            end
         end
         ect_pkg::OP_READ: begin
            i = find_slot(r.handle);
            if (i < 0) o.status = ect_pkg::ST_BADH;
            else if (tbl_count[i] == 0) o.status = ect_pkg::ST_BLOCK;
            else if (tbl_sem[i]) begin
               o.read_value = 64'd1; tbl_count[i] = tbl_count[i] - 64'd1;
            end else begin
               o.read_value = tbl_count[i]; tbl_count[i] = '0;
            end
         end
         ect_pkg::OP_WRITE: begin
            i = find_slot(r.handle);
            if (i < 0) o.status = ect_pkg::ST_BADH;
            else begin
               sum = tbl_count[i] + r.add_value;
               if (sum < tbl_count[i]) o.status = ect_pkg::ST_OVF;
               else tbl_count[i] = sum;
            end
         end
         ect_pkg::OP_CLOSE: begin
            i = find_slot(r.handle);
            if (i < 0) o.status = ect_pkg::ST_BADH;
            else begin
               tbl_used[i] = 0; tbl_owner[i] = '0; tbl_count[i] = '0;
            end
         end
         ect_pkg::OP_CLOSE_OWNER: begin
            for (int k = 0; k < NSLOT; k++)
               if (tbl_used[k] && tbl_owner[k] == r.owner) begin
                  tbl_used[k] = 0; tbl_owner[k] = '0; tbl_count[k] = '0;
               end
         end
         ect_pkg::OP_POLL: begin
            i = find_slot(r.handle);
            if (i < 0) o.status = ect_pkg::ST_BADH;
            else begin
               o.readable = tbl_count[i] != 0;
               o.writable = tbl_count[i] != '1;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // handle likely to hit: a live one, one near the allocator, or a random one
   function automatic logic [30:0] pick_handle();
      int i;
      case ($urandom_range(0, 9))
         0: return 31'($urandom);
         1: return tbl_next - 31'($urandom_range(0, 3));
         default: begin
            i = $urandom_range(0, NSLOT - 1);
            return tbl_used[i] ? tbl_handle[i] : tbl_next - 31'($urandom_range(1, 80));
         end
      endcase
   endfunction

   function automatic logic [63:0] rand64();
      case ($urandom_range(0, 5))
         0: return '1;
         1: return '1 - 64'($urandom_range(0, 3));
         2: return 64'($urandom_range(0, 5));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic request_type make_req(logic [2:0] m, logic [30:0] h, logic [31:0] iv,
                                            logic s, logic [31:0] ow, logic [63:0] av);
      request_type r;
      r.mode = m; r.handle = h; r.init_value = iv; r.semaphore_mode = s;
      r.owner = ow; r.add_value = av;
      return r;
   endfunction

   // sampled handshakes at the rising edge
   logic req_tready_q = 0;
   always @(posedge clock) req_tready_q <= req_tvalid & req_tready;

   // driver: one request at a time, random gap before each
   int drv_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready_q) begin
            sent <= sent + 1;
            if (pending_reqs.size() > 0 && drv_gap == 0) begin
               req_tdata <= {5'd0, pending_reqs.pop_front()};
               drv_gap <= $urandom_range(0, 8);
            end else req_tvalid <= 0;
         end else if (!req_tvalid && pending_reqs.size() > 0) begin
            if (drv_gap > 0) drv_gap <= drv_gap - 1;
            else begin
               req_tdata <= {5'd0, pending_reqs.pop_front()};
               req_tvalid <= 1;
               drv_gap <= $urandom_range(0, 8);
            end
         end else if (drv_gap > 0) drv_gap <= drv_gap - 1;
      end
   end

   always @(posedge clock) begin
      response_type got, exp_r;
      if (!reset && req_tvalid && req_tready)
         expected_rsps.push_back(predict_counter_op(request_type'(req_tdata[162:0])));
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = response_type'(rsp_tdata[99:0]);
         if (expected_rsps.size() == 0) begin
            $display("%0t unexpected response exp none got %h", $time, got);
            errors++;
         end else begin
            exp_r = expected_rsps.pop_front();
            if (got.status !== exp_r.status)
               $display("%0t status exp %0d got %0d", $time, exp_r.status, got.status);
            if (got.new_handle !== exp_r.new_handle)
               $display("%0t new_handle exp %0d got %0d", $time, exp_r.new_handle,
                        got.new_handle);
            if (got.read_value !== exp_r.read_value)
               $display("%0t read_value exp %0d got %0d", $time, exp_r.read_value,
                        got.read_value);
            if (got.readable !== exp_r.readable)
               $display("%0t readable exp %b got %b", $time, exp_r.readable, got.readable);
            if (got.writable !== exp_r.writable)
               $display("%0t writable exp %b got %b", $time, exp_r.writable, got.writable);
            if (got !== exp_r) errors++;
         end
      end
      if (!reset && !((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)))
         idle_cycles <= idle_cycles + 1;
      else idle_cycles <= 0;
   end

   // receiver: random stalls, plus one long hold-off counted here while the
   // sender keeps going
   int rcv_gap = 0;
   always @(negedge clock) begin
      if (hold_go && !hold_seen) begin
         hold_seen = 1;
         hold_left = 200;
      end
      if (reset) rsp_tready <= 0;
      else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 0;
      end else if (rsp_tready && rsp_tvalid) begin
         rcv_gap = $urandom_range(0, 8);
         rsp_tready <= (rcv_gap == 0) || ($urandom_range(0, 3) == 0);
      end else if (rcv_gap > 0) begin
         rcv_gap--;
         rsp_tready <= 0;
      end else rsp_tready <= 1;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 0;
      for (int i = 0; i < NSLOT; i++) tbl_used[i] = 0;
      tbl_next = ect_pkg::DEF_FIRST_HANDLE;
   end

   initial begin : stim
      request_type r;
      // wait out reset, by which time the predictor is initialised
      @(negedge reset);
      @(posedge clock);
      // directed: read/poll unknown, creates, would-block, overflow, close paths, unused modes
      pending_reqs.push_back(make_req(ect_pkg::OP_READ, 31'h7fffffff, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(ect_pkg::OP_POLL, 31'd0, 0, 1, 0, 0));
      pending_reqs.push_back(make_req(ect_pkg::OP_CREATE, 0, 32'd0, 0, 32'hffffffff, '1));
      pending_reqs.push_back(make_req(ect_pkg::OP_READ, 31'd12000, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(ect_pkg::OP_WRITE, 31'd12000, 0, 0, 0, '1));
      pending_reqs.push_back(make_req(ect_pkg::OP_POLL, 31'd12000, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(ect_pkg::OP_WRITE, 31'd12000, 0, 0, 0, 64'd1));
      pending_reqs.push_back(make_req(ect_pkg::OP_READ, 31'd12000, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(ect_pkg::OP_CREATE, 31'h7fffffff, 32'hffffffff, 1,
                                      0, 0));
      pending_reqs.push_back(make_req(ect_pkg::OP_READ, 31'd12001, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(ect_pkg::OP_POLL, 31'd12001, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(ect_pkg::OP_CLOSE, 31'd12001, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(ect_pkg::OP_CLOSE, 31'd12001, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(ect_pkg::OP_CLOSE_OWNER, 0, 0, 0, 32'hffffffff, 0));
      pending_reqs.push_back(make_req(ect_pkg::OP_CLOSE_OWNER, 0, 0, 0, 32'h12345678, 0));
      pending_reqs.push_back(make_req(3'd6, '1, '1, 1, '1, '1));
      pending_reqs.push_back(make_req(3'd7, 0, 0, 0, 0, 0));
      // fill the table past full
      for (int i = 0; i < NSLOT + 2; i++)
         pending_reqs.push_back(make_req(ect_pkg::OP_CREATE, 0, $urandom,
                                         $urandom_range(0, 1),
                                         32'($urandom_range(0, 3)), 0));
      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !req_tvalid);
      // long receiver hold-off while the sender keeps offering
      hold_go = 1;
      wait (hold_seen);
      for (int i = 0; i < 10; i++)
         pending_reqs.push_back(make_req(ect_pkg::OP_POLL, pick_handle(), 0, 0, 0, 0));
      wait (hold_seen && hold_left == 0);
      // random phases; predictor state is advanced only at acceptance, so
      // handle picks are made against a slightly stale table, which is fine
      for (int n = 0; n < 450; n++) begin
         r = make_req(3'($urandom_range(0, 5)), pick_handle(), $urandom,
                      $urandom_range(0, 1), 32'($urandom_range(0, 3)), rand64());
         if ($urandom_range(0, 30) == 0) r.mode = 3'($urandom_range(6, 7));
         if ($urandom_range(0, 20) == 0) r.owner = $urandom;
         pending_reqs.push_back(r);
         if (n % 110 == 109)
            wait (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !req_tvalid);
         else
            wait (pending_reqs.size() < 4);
      end
      wait (pending_reqs.size() == 0 && !req_tvalid);
      wait (expected_rsps.size() == 0);
      repeat (20) @(posedge clock);
      stim_done = 1;
   end

   initial begin : finish_ctl
      wait (stim_done || idle_cycles >= TIMEOUT);
      if (!stim_done) begin
         $display("TB_ERROR");
      end else if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
